/* rtl/core/rrss_pkg.sv */
package rrss_pkg;

  localparam int unsigned MaxProcs = 16;
  localparam int unsigned IdxW     = (MaxProcs > 1) ? $clog2(MaxProcs) : 1;
  localparam int unsigned CntW     = $clog2(MaxProcs + 1);

  localparam int unsigned TicksW   = 16;
  localparam int unsigned TimeW    = 32;
  localparam int unsigned PnumW    = 5;
  localparam int unsigned ModeW    = 2;

  localparam logic [ModeW-1:0] ModeLoad     = 2'd0;
  localparam logic [ModeW-1:0] ModeDispatch = 2'd1;
  localparam logic [ModeW-1:0] ModeClear    = 2'd2;
  localparam logic [ModeW-1:0] ModeUnused   = 2'd3;

  localparam logic [TicksW-1:0] QuantumReset = 16'd4;

  // Advance a ring position by an offset of at most MaxProcs.
  function automatic logic [IdxW-1:0] ring_pos(input logic [IdxW-1:0] base,
                                               input logic [CntW-1:0] offs);
    logic [CntW:0] sum;
    sum = {{(CntW + 1 - IdxW){1'b0}}, base} + {1'b0, offs};
    if (sum >= (CntW + 1)'(MaxProcs)) begin
      sum = sum - (CntW + 1)'(MaxProcs);
    end
    return sum[IdxW-1:0];
  endfunction

endpackage

/* rtl/core/rrss_ram.sv */
module rrss_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                                       clk_i,
  input  logic                                       we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                           wdata_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                           rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* rtl/core/round_robin_slice_scheduler.sv */
// Round-robin time-slice scheduler. An item is taken when start_i is high and
// busy_o is low; its result appears on the result ports in the cycle after the
// item completes, for one cycle only, marked by done_o, and must be captured
// then. For load, clear, the unused mode and a dispatch on an empty queue the
// result follows the accepting edge directly. A dispatch that runs a slice
// passes through StReadRing, StReadRem and StExec with busy_o high: the ring
// read issued at acceptance gives the process index, which is registered,
// then addresses the remaining-time RAM, and the update is written back at the
// end of StExec. The user must write the quantum with quantum_we_i only while
// the block is idle; the block does not enforce this. A clear keeps the quantum.
module round_robin_slice_scheduler (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  output logic                        busy_o,
  input  logic [rrss_pkg::ModeW-1:0]  mode_i,
  input  logic [rrss_pkg::TicksW-1:0] burst_time_i,
  input  logic                        quantum_we_i,
  input  logic [rrss_pkg::TicksW-1:0] quantum_i,
  output logic                        done_o,
  output logic                        slice_valid_o,
  output logic [rrss_pkg::PnumW-1:0]  process_number_o,
  output logic [rrss_pkg::TimeW-1:0]  slice_start_o,
  output logic [rrss_pkg::TimeW-1:0]  slice_end_o,
  output logic                        process_finished_o,
  output logic                        all_done_o,
  output logic                        load_rejected_o
);
  import rrss_pkg::*;

  localparam logic [1:0] StIdle     = 2'd0;
  localparam logic [1:0] StReadRing = 2'd1;
  localparam logic [1:0] StReadRem  = 2'd2;
  localparam logic [1:0] StExec     = 2'd3;

  logic [1:0]        state_q, state_d;
  logic [IdxW-1:0]   head_q, head_d;
  logic [CntW-1:0]   count_q, count_d;
  logic [CntW-1:0]   loaded_q, loaded_d;
  logic [TimeW-1:0]  time_q, time_d;
  logic [TicksW-1:0] quantum_q;
  logic [IdxW-1:0]   idx_q, idx_d;

  logic              done_q, done_d;
  logic              valid_q, valid_d;
  logic [PnumW-1:0]  pnum_q, pnum_d;
  logic [TimeW-1:0]  start_q, start_d;
  logic [TimeW-1:0]  end_q, end_d;
  logic              fin_q, fin_d;
  logic              alldone_q, alldone_d;
  logic              rej_q, rej_d;

  logic              ring_we;
  logic [IdxW-1:0]   ring_waddr, ring_wdata, ring_rdata;
  logic              rem_we;
  logic [IdxW-1:0]   rem_waddr;
  logic [TicksW-1:0] rem_wdata, rem_rdata;

  logic              accept;
  logic [IdxW-1:0]   tail_pos;
  logic              fits;

  assign accept   = start_i && (state_q == StIdle);
  assign tail_pos = ring_pos(head_q, count_q);
  assign fits     = (rem_rdata <= quantum_q);

  rrss_ram #(.Width(IdxW), .Depth(MaxProcs)) u_ring_ram (
    .clk_i   (clk_i),
    .we_i    (ring_we),
    .waddr_i (ring_waddr),
    .wdata_i (ring_wdata),
    .raddr_i (head_q),
    .rdata_o (ring_rdata)
  );

  rrss_ram #(.Width(TicksW), .Depth(MaxProcs)) u_rem_ram (
    .clk_i   (clk_i),
    .we_i    (rem_we),
    .waddr_i (rem_waddr),
    .wdata_i (rem_wdata),
    .raddr_i (idx_q),
    .rdata_o (rem_rdata)
  );

  always_comb begin
    state_d   = state_q;
    head_d    = head_q;
    count_d   = count_q;
    loaded_d  = loaded_q;
    time_d    = time_q;
    idx_d     = idx_q;

    done_d    = 1'b0;
    valid_d   = 1'b0;
    pnum_d    = '0;
    start_d   = '0;
    end_d     = '0;
    fin_d     = 1'b0;
    alldone_d = (count_q == '0);
    rej_d     = 1'b0;

    ring_we    = 1'b0;
    ring_waddr = tail_pos;
    ring_wdata = loaded_q[IdxW-1:0];
    rem_we     = 1'b0;
    rem_waddr  = loaded_q[IdxW-1:0];
    rem_wdata  = burst_time_i;

    case (state_q)
      StIdle: begin
        if (accept) begin
          case (mode_i)
            ModeLoad: begin
              done_d = 1'b1;
              if (loaded_q < CntW'(MaxProcs)) begin
                ring_we   = 1'b1;
                rem_we    = 1'b1;
                count_d   = count_q + 1'b1;
                loaded_d  = loaded_q + 1'b1;
                alldone_d = 1'b0;
              end else begin
                rej_d = 1'b1;
              end
            end
            ModeDispatch: begin
              if (count_q == '0) begin
                done_d = 1'b1;
              end else begin
                state_d = StReadRing;
              end
            end
            ModeClear: begin
              done_d    = 1'b1;
              head_d    = '0;
              count_d   = '0;
              loaded_d  = '0;
              time_d    = '0;
              alldone_d = 1'b1;
            end
            default: begin
              done_d = 1'b1;
            end
          endcase
        end
      end
      StReadRing: begin
        // ring data now holds the head entry
        idx_d   = ring_rdata;
        state_d = StReadRem;
      end
      StReadRem: begin
        state_d = StExec;
      end
      StExec: begin
        state_d = StIdle;
        done_d  = 1'b1;
        valid_d = 1'b1;
        pnum_d  = PnumW'({1'b0, idx_q} + 1'b1);
        start_d = time_q;
        head_d  = ring_pos(head_q, CntW'(1));
        rem_we    = 1'b1;
        rem_waddr = idx_q;
        if (fits) begin
          rem_wdata = '0;
          time_d    = time_q + TimeW'(rem_rdata);
          fin_d     = 1'b1;
          count_d   = count_q - 1'b1;
          alldone_d = (count_q == CntW'(1));
        end else begin
          // charge one quantum and requeue at the tail
          rem_wdata  = rem_rdata - quantum_q;
          time_d     = time_q + TimeW'(quantum_q);
          ring_we    = 1'b1;
          ring_wdata = idx_q;
          alldone_d  = 1'b0;
        end
        end_d = time_d;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      head_q    <= '0;
      count_q   <= '0;
      loaded_q  <= '0;
      time_q    <= '0;
      quantum_q <= QuantumReset;
      done_q    <= 1'b0;
    end else begin
      state_q  <= state_d;
      head_q   <= head_d;
      count_q  <= count_d;
      loaded_q <= loaded_d;
      time_q   <= time_d;
      done_q   <= done_d;
      if (quantum_we_i) begin
        quantum_q <= quantum_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q     <= idx_d;
    valid_q   <= valid_d;
    pnum_q    <= pnum_d;
    start_q   <= start_d;
    end_q     <= end_d;
    fin_q     <= fin_d;
    alldone_q <= alldone_d;
    rej_q     <= rej_d;
  end

  assign busy_o             = (state_q != StIdle);
  assign done_o             = done_q;
  assign slice_valid_o      = valid_q;
  assign process_number_o   = pnum_q;
  assign slice_start_o      = start_q;
  assign slice_end_o        = end_q;
  assign process_finished_o = fin_q;
  assign all_done_o         = alldone_q;
  assign load_rejected_o    = rej_q;

endmodule

/* sim/round_robin_slice_scheduler_tb.sv */
module round_robin_slice_scheduler_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rrss_pkg::*;

  typedef struct {
    logic             slice_valid;
    logic [PnumW-1:0] process_number;
    logic [TimeW-1:0] slice_start;
    logic [TimeW-1:0] slice_end;
    logic             process_finished;
    logic             all_done;
    logic             load_rejected;
  } slice_rec_t;

  logic              clk_i;
  logic              rst_ni;
  logic              start_i;
  logic              busy_o;
  logic [ModeW-1:0]  mode_i;
  logic [TicksW-1:0] burst_time_i;
  logic              quantum_we_i;
  logic [TicksW-1:0] quantum_i;
  logic              done_o;
  logic              slice_valid_o;
  logic [PnumW-1:0]  process_number_o;
  logic [TimeW-1:0]  slice_start_o;
  logic [TimeW-1:0]  slice_end_o;
  logic              process_finished_o;
  logic              all_done_o;
  logic              load_rejected_o;

  // scheduler state as the testbench sees it
  logic [TicksW-1:0] ticks_left [MaxProcs];
  logic [IdxW-1:0]   run_ring   [MaxProcs];
  logic [IdxW-1:0]   ring_first;
  logic [CntW-1:0]   ring_fill;
  logic [CntW-1:0]   procs_loaded;
  logic [TimeW-1:0]  sched_time;
  logic [TicksW-1:0] quantum;

  slice_rec_t  pending_slices [$];
  slice_rec_t  want;
  int unsigned mismatch_count;
  int unsigned items_sent;
  int unsigned slices_seen;
  int unsigned finishes_seen;
  int unsigned rejects_seen;

  round_robin_slice_scheduler DUT (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start_i            (start_i),
    .busy_o             (busy_o),
    .mode_i             (mode_i),
    .burst_time_i       (burst_time_i),
    .quantum_we_i       (quantum_we_i),
    .quantum_i          (quantum_i),
    .done_o             (done_o),
    .slice_valid_o      (slice_valid_o),
    .process_number_o   (process_number_o),
    .slice_start_o      (slice_start_o),
    .slice_end_o        (slice_end_o),
    .process_finished_o (process_finished_o),
    .all_done_o         (all_done_o),
    .load_rejected_o    (load_rejected_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #400_000;
    $display("round_robin_slice_scheduler verification failed");
    $finish;
  end

  function automatic slice_rec_t schedule_slice(input logic [ModeW-1:0]  mode,
                                                input logic [TicksW-1:0] burst);
    slice_rec_t        r;
    logic [IdxW-1:0]   pid;
    logic [TicksW-1:0] left;
    r = '{default: '0};
    if (mode == ModeLoad) begin
      if (procs_loaded < CntW'(MaxProcs)) begin
        ticks_left[procs_loaded[IdxW-1:0]] = burst;
        run_ring[IdxW'(ring_first + ring_fill)] = procs_loaded[IdxW-1:0];
        ring_fill = ring_fill + 1'b1;
        procs_loaded = procs_loaded + 1'b1;
      end else begin
        r.load_rejected = 1'b1;
      end
    end else if (mode == ModeDispatch) begin
      if (ring_fill != 0) begin
        pid = run_ring[ring_first];
        left = ticks_left[pid];
        ring_first = ring_first + 1'b1;
        ring_fill = ring_fill - 1'b1;
        r.slice_valid = 1'b1;
        r.process_number = PnumW'(pid) + 1'b1;
        r.slice_start = sched_time;
        if (left <= quantum) begin
          sched_time = sched_time + TimeW'(left);
          ticks_left[pid] = '0;
          r.process_finished = 1'b1;
        end else begin
          // charge one quantum and requeue at the tail
          ticks_left[pid] = left - quantum;
          sched_time = sched_time + TimeW'(quantum);
          run_ring[IdxW'(ring_first + ring_fill)] = pid;
          ring_fill = ring_fill + 1'b1;
        end
        r.slice_end = sched_time;
      end
    end else if (mode == ModeClear) begin
      ring_first = '0;
      ring_fill = '0;
      procs_loaded = '0;
      sched_time = '0;
    end
    r.all_done = (ring_fill == 0);
    return r;
  endfunction

  function automatic void check_field(input string field, input logic [TimeW-1:0] want_v,
                                      input logic [TimeW-1:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected %0h, got %0h", field, want_v, got_v);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && done_o === 1'b1) begin
      if (pending_slices.size() == 0) begin
        $error("result arrived with no item outstanding");
        mismatch_count++;
      end else begin
        want = pending_slices.pop_front();
        check_field("slice_valid", want.slice_valid, slice_valid_o);
        check_field("process_number", want.process_number, process_number_o);
        check_field("slice_start", want.slice_start, slice_start_o);
        check_field("slice_end", want.slice_end, slice_end_o);
        check_field("process_finished", want.process_finished, process_finished_o);
        check_field("all_done", want.all_done, all_done_o);
        check_field("load_rejected", want.load_rejected, load_rejected_o);
        slices_seen += want.slice_valid;
        finishes_seen += want.process_finished;
        rejects_seen += want.load_rejected;
      end
    end
  end

  // Called at a rising edge; leaves start high so a following item goes straight on.
  task automatic send_item(input logic [ModeW-1:0] mode, input logic [TicksW-1:0] burst);
    start_i <= 1'b1;
    mode_i <= mode;
    burst_time_i <= burst;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    pending_slices.push_back(schedule_slice(mode, burst));
    items_sent++;
  endtask

  task automatic sender_gap(input int unsigned cycles);
    start_i <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  // Hold off until every outstanding result is back and the block has settled.
  task automatic drain();
    start_i <= 1'b0;
    while (pending_slices.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_quantum(input logic [TicksW-1:0] q);
    drain();
    quantum_we_i <= 1'b1;
    quantum_i <= q;
    @(posedge clk_i);
    quantum_we_i <= 1'b0;
    quantum = q;
  endtask

  function automatic logic [TicksW-1:0] pick_burst();
    int unsigned top;
    top = 3 * int'(quantum);
    if (top > 65535) top = 65535;
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return TicksW'($urandom);
      default: return TicksW'($urandom_range(0, top));
    endcase
  endfunction

  task automatic test_empty_dispatch();
    send_item(ModeDispatch, TicksW'($urandom));
  endtask

  // exact fit, one over the quantum, zero burst, and a load once dispatch has begun
  task automatic test_quantum_edges();
    send_item(ModeLoad, 16'd4);
    send_item(ModeLoad, 16'd5);
    send_item(ModeLoad, 16'd0);
    send_item(ModeDispatch, '0);
    send_item(ModeLoad, 16'd3);
    repeat (4) send_item(ModeDispatch, '1);
  endtask

  task automatic test_table_full();
    send_item(ModeLoad, 16'hFFFF);
    send_item(ModeLoad, 16'h0000);
    repeat (10) send_item(ModeLoad, TicksW'($urandom));
    send_item(ModeLoad, 16'h5A5A);
  endtask

  task automatic test_clear_keeps_quantum();
    write_quantum(16'd7);
    send_item(ModeClear, '1);
    send_item(ModeLoad, 16'd9);
    send_item(ModeDispatch, '0);
    send_item(ModeDispatch, '0);
  endtask

  task automatic test_random_schedule(input logic [TicksW-1:0] q, input int unsigned n,
                                      input bit gaps, input bit hold_mid);
    int unsigned      pick;
    bit               gappy;
    logic [ModeW-1:0] mode;
    write_quantum(q);
    send_item(ModeClear, TicksW'($urandom));
    gappy = 1'b0;
    for (int k = 0; k < n; k++) begin
      if (k % 40 == 0) gappy = gaps && ($urandom_range(0, 1) == 1);
      if (hold_mid && k == n / 2) drain();
      pick = $urandom_range(0, 99);
      if (pick < 2) mode = ModeClear;
      else if (pick < 4) mode = ModeUnused;
      else if (pick < 40) mode = ModeLoad;
      else mode = ModeDispatch;
      send_item(mode, pick_burst());
      if (gappy && $urandom_range(0, 2) == 0) sender_gap($urandom_range(1, 7));
    end
  endtask

  initial begin
    start_i = 1'b0;
    mode_i = ModeLoad;
    burst_time_i = '0;
    quantum_we_i = 1'b0;
    quantum_i = '0;
    rst_ni = 1'b0;
    ring_first = '0;
    ring_fill = '0;
    procs_loaded = '0;
    sched_time = '0;
    quantum = QuantumReset;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_dispatch();
    test_quantum_edges();
    test_table_full();
    test_clear_keeps_quantum();
    test_random_schedule(16'd1, 200, 1'b1, 1'b0);
    test_random_schedule(16'hFFFF, 200, 1'b1, 1'b0);
    test_random_schedule(TicksW'($urandom_range(2, 10)), 300, 1'b1, 1'b1);
    test_random_schedule(TicksW'($urandom_range(1, 65535)), 200, 1'b1, 1'b0);
    test_random_schedule(QuantumReset, 300, 1'b0, 1'b0);
    drain();

    $display("Ran %0d items: %0d slices dispatched, %0d processes completed, %0d loads refused.",
             items_sent, slices_seen, finishes_seen, rejects_seen);
    $display("Quanta 1, 4, 7, 65535 and random values; sender gaps in all but the last phase.");
    if (mismatch_count == 0) begin
      $display("round_robin_slice_scheduler verification clean");
    end else begin
      $display("round_robin_slice_scheduler verification failed");
    end
    $finish;
  end

endmodule
